// File: design/xs128_pkg.sv
// Shared types, constants and the state-update function of the xorshift128+ generator.
`default_nettype none
package xs128_pkg;

	localparam logic [1:0] OP_SEED  = 2'd0;
	localparam logic [1:0] OP_DRAW  = 2'd1;
	localparam logic [1:0] OP_JUMP  = 2'd2;
	localparam logic [1:0] OP_RANGE = 2'd3;

	localparam int ShiftA = 23;
	localparam int ShiftB = 18;
	localparam int ShiftC = 5;

	localparam logic [63:0] SEED_FIRST_RST  = 64'd12342;
	localparam logic [63:0] SEED_SECOND_RST = 64'd22342;

	localparam logic [127:0] JUMP_POLY = {64'h121fd2155c472f96, 64'h8a5cd789635d2dff};

	localparam int DivSteps = 64;

	typedef struct packed {
		logic [63:0] first;
		logic [63:0] second;
	} xs_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} xs_mod_stat_t;

	function automatic xs_state_t xs_advance(input xs_state_t s);
		xs_state_t   r;
		logic [63:0] a;
		a        = s.first ^ (s.first << ShiftA);
		r.first  = s.second;
		r.second = a ^ s.second ^ (a >> ShiftB) ^ (s.second >> ShiftC);
		return r;
	endfunction

endpackage
`default_nettype wire

// File: design/xorshift128plus_ranged_generator.sv
// Top level of the xorshift128+ generator with seed, draw, jump and ranged-draw requests.
//
//  channel  | valid      | stall      | payload
//  ---------+------------+------------+-----------------------------------------------
//  request  | in_valid   | in_stall   | operation, seed_first, seed_second,
//           |            |            | range_lower, range_upper
//  result   | out_valid  | out_stall  | random_word, ranged_value
//
// Seed, draw and equal-bound ranged draws give their result in the cycle after acceptance.
// Jump steps through the polynomial bits one by one, advancing with the one shared state-update unit.
// Ranged draws with distinct bounds wait on the one-bit-per-cycle remainder unit.
// One request is in work at a time; a new one is taken as the pending result leaves.
// Reset loads the state words 12342 and 22342 and empties the result register.
`default_nettype none
module xorshift128plus_ranged_generator (
	input  wire  logic               clk,
	input  wire  logic               arst_n,
	input  wire  logic               in_valid,
	output       logic               in_stall,
	input  wire  logic [1:0]         operation,
	input  wire  logic [63:0]        seed_first,
	input  wire  logic [63:0]        seed_second,
	input  wire  logic signed [31:0] range_lower,
	input  wire  logic signed [31:0] range_upper,
	output       logic               out_valid,
	input  wire  logic               out_stall,
	output       logic [63:0]        random_word,
	output       logic signed [31:0] ranged_value
);
	import xs128_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_JUMP = 2'd1;
	localparam logic [1:0] ST_MOD  = 2'd2;

	logic [1:0]   state_q;
	logic [6:0]   jcnt_q;
	xs_state_t    gen_q;
	xs_state_t    acc_q;
	xs_state_t    gen_next;
	xs_state_t    acc_next;
	logic         out_valid_q;
	logic [63:0]  word_q;
	logic [31:0]  ranged_q;
	logic [31:0]  lo_q;

	logic         accept;
	logic         out_free;
	logic [31:0]  lo_sel;
	logic [31:0]  hi_sel;
	logic         bounds_eq;
	logic [63:0]  sum;
	logic         poly_bit;
	logic         mod_start;
	logic [32:0]  divisor;
	logic [31:0]  remainder;
	xs_mod_stat_t mod_stat;

	assign out_free = !(out_valid_q && out_stall);
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		if (range_upper < range_lower) begin
			lo_sel = range_upper;
			hi_sel = range_lower;
		end else begin
			lo_sel = range_lower;
			hi_sel = range_upper;
		end
		bounds_eq = (lo_sel == hi_sel);
		divisor   = {1'b0, hi_sel - lo_sel} + 33'd1;
		sum       = gen_q.first + gen_q.second;
		gen_next  = xs_advance(gen_q);
		poly_bit  = JUMP_POLY[jcnt_q];
		acc_next  = poly_bit ? (acc_q ^ gen_q) : acc_q;
	end

	assign mod_start = accept && (operation == OP_RANGE) && !bounds_eq;

	xs128_modu u_modu (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (sum),
		.divisor   (divisor),
		.remainder (remainder),
		.stat      (mod_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			jcnt_q       <= '0;
			gen_q.first  <= SEED_FIRST_RST;
			gen_q.second <= SEED_SECOND_RST;
			out_valid_q  <= 1'b0;
		end else begin
			if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (operation)
							OP_SEED: begin
								gen_q.first  <= seed_first;
								gen_q.second <= seed_second;
								out_valid_q  <= 1'b1;
							end
							OP_DRAW: begin
								gen_q       <= gen_next;
								out_valid_q <= 1'b1;
							end
							OP_JUMP: begin
								jcnt_q  <= '0;
								state_q <= ST_JUMP;
							end
							OP_RANGE: begin
								if (bounds_eq) begin
									out_valid_q <= 1'b1;
								end else begin
									gen_q   <= gen_next;
									state_q <= ST_MOD;
								end
							end
							default: ;
						endcase
					end
				end
				ST_JUMP: begin
					jcnt_q <= jcnt_q + 1'b1;
					if (&jcnt_q) begin
						gen_q       <= acc_next;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						gen_q <= gen_next;
					end
				end
				ST_MOD: begin
					if (mod_stat.done) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lo_q <= lo_sel;
			unique case (operation)
				OP_SEED, OP_JUMP: begin
					word_q   <= '0;
					ranged_q <= '0;
				end
				OP_DRAW: begin
					word_q   <= sum;
					ranged_q <= '0;
				end
				OP_RANGE: begin
					word_q   <= bounds_eq ? 64'd0 : sum;
					ranged_q <= bounds_eq ? lo_sel : 32'd0;
				end
				default: ;
			endcase
		end else if (state_q == ST_MOD && mod_stat.done) begin
			ranged_q <= remainder + lo_q;
		end
		if (state_q == ST_JUMP) begin
			acc_q <= (jcnt_q == '0) ? (poly_bit ? gen_q : '0) : acc_next;
		end else if (accept) begin
			acc_q <= '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign random_word  = word_q;
	assign ranged_value = ranged_q;

endmodule
`default_nettype wire

// File: design/xs128_modu.sv
// Restoring remainder unit: 64-bit word modulo a 33-bit divisor, one quotient bit per cycle.
`default_nettype none
module xs128_modu (
	input  wire  logic                     clk,
	input  wire  logic                     arst_n,
	input  wire  logic                     start,
	input  wire  logic [63:0]              dividend,
	input  wire  logic [32:0]              divisor,
	output       logic [31:0]              remainder,
	output       xs128_pkg::xs_mod_stat_t  stat
);
	import xs128_pkg::*;

	localparam int CntW = $clog2(DivSteps);
	localparam logic [CntW-1:0] LastCnt = CntW'(DivSteps - 1);

	logic            run_q;
	logic            done_q;
	logic [CntW-1:0] cnt_q;
	logic [31:0]     rem_q;
	logic [63:0]     dvd_q;
	logic [32:0]     div_q;
	logic [32:0]     trial;
	logic [32:0]     rem_next;

	always_comb begin
		trial    = {rem_q, dvd_q[63]};
		rem_next = (trial >= div_q) ? (trial - div_q) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LastCnt) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			div_q <= divisor;
		end else if (run_q) begin
			rem_q <= rem_next[31:0];
			dvd_q <= {dvd_q[62:0], 1'b0};
		end
	end

	assign remainder = rem_q;
	assign stat.busy = run_q;
	assign stat.done = done_q;

endmodule
`default_nettype wire
